FILE: rtl/follow_robot_mode_controller_top_macros.svh
// Assertion macros shared by the follow robot mode controller RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef FOLLOW_ROBOT_MODE_CONTROLLER_TOP_MACROS_SVH
`define FOLLOW_ROBOT_MODE_CONTROLLER_TOP_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define FRMC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("frmc invariant violated");

// The consequent must hold in the same cycle as the antecedent.
`define FRMC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frmc implication violated");

// The consequent must hold in the cycle after the antecedent.
`define FRMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frmc next-cycle implication violated");

`endif

FILE: rtl/frmc_pkg.sv
// Package for the follow robot mode controller: widths, codes and shared types.
// It has no dependencies; every RTL module imports it.
package frmc_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int DWELL_BITS     = 16;
    localparam int DWELL_OUT_BITS = DWELL_BITS + 1;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = (DWELL_BITS > SAMPLE_BITS) ? DWELL_BITS : SAMPLE_BITS;
    localparam int MODE_BITS      = 2;
    localparam int SIDE_BITS      = 2;
    localparam int CMD_BITS       = 4;

    localparam logic [MODE_BITS-1:0] MODE_INACTIVE = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_OBJECT   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_WALL     = 2'd2;

    localparam logic [SIDE_BITS-1:0] SIDE_NONE  = 2'd0;
    localparam logic [SIDE_BITS-1:0] SIDE_LEFT  = 2'd1;
    localparam logic [SIDE_BITS-1:0] SIDE_RIGHT = 2'd2;

    localparam logic [CMD_BITS-1:0] CMD_HOLD   = 4'd0;
    localparam logic [CMD_BITS-1:0] CMD_STOP   = 4'd1;
    localparam logic [CMD_BITS-1:0] CMD_FWD    = 4'd2;
    localparam logic [CMD_BITS-1:0] CMD_BACK   = 4'd3;
    localparam logic [CMD_BITS-1:0] CMD_LFWD   = 4'd4;
    localparam logic [CMD_BITS-1:0] CMD_LBACK  = 4'd5;
    localparam logic [CMD_BITS-1:0] CMD_RFWD   = 4'd6;
    localparam logic [CMD_BITS-1:0] CMD_RBACK  = 4'd7;
    localparam logic [CMD_BITS-1:0] CMD_RPIVOT = 4'd8;
    localparam logic [CMD_BITS-1:0] CMD_LPIVOT = 4'd9;
    localparam logic [CMD_BITS-1:0] CMD_FASTL  = 4'd10;
    localparam logic [CMD_BITS-1:0] CMD_FASTR  = 4'd11;
    localparam logic [CMD_BITS-1:0] CMD_SHARPL = 4'd12;
    localparam logic [CMD_BITS-1:0] CMD_SHARPR = 4'd13;

    localparam logic [CFG_IDX_BITS-1:0] REG_TOO_FAR      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FOLLOW_FAR   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FOLLOW_CLOSE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOO_CLOSE    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PIVOT_DWELL  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_WALL_DWELL   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_OBJECT_DWELL = 3'd6;

    localparam logic [SAMPLE_BITS-1:0] RST_TOO_FAR      = SAMPLE_BITS'(600);
    localparam logic [SAMPLE_BITS-1:0] RST_FOLLOW_FAR   = SAMPLE_BITS'(1500);
    localparam logic [SAMPLE_BITS-1:0] RST_FOLLOW_CLOSE = SAMPLE_BITS'(2000);
    localparam logic [SAMPLE_BITS-1:0] RST_TOO_CLOSE    = SAMPLE_BITS'(3000);
    localparam logic [DWELL_BITS-1:0]  RST_PIVOT_DWELL  = DWELL_BITS'(1000);
    localparam logic [DWELL_BITS-1:0]  RST_WALL_DWELL   = DWELL_BITS'(500);
    localparam logic [DWELL_BITS-1:0]  RST_OBJECT_DWELL = DWELL_BITS'(500);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] too_far;
        logic [SAMPLE_BITS-1:0] fwd_edge;
        logic [SAMPLE_BITS-1:0] back_edge;
        logic [SAMPLE_BITS-1:0] close_limit;
        logic [DWELL_BITS-1:0]  pivot_dwell;
        logic [DWELL_BITS-1:0]  wall_dwell;
        logic [DWELL_BITS-1:0]  object_dwell;
    } cfg_t;

    typedef struct packed {
        logic                   req_type;
        logic [SAMPLE_BITS-1:0] ahead;
        logic [SAMPLE_BITS-1:0] left;
        logic [SAMPLE_BITS-1:0] right;
        logic                   sw1;
        logic                   sw2;
    } item_t;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic                 armed;
        logic                 acquired;
        logic [SIDE_BITS-1:0] side;
    } state_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]       cmd;
        logic [DWELL_OUT_BITS-1:0] dwell;
        logic [MODE_BITS-1:0]      mode;
    } result_t;

endpackage

FILE: rtl/frmc_cfg_regs.sv
// Configuration register file of the follow robot mode controller.
// Depends on frmc_pkg for register indexes, widths and reset values.
module frmc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [frmc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [frmc_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output frmc_pkg::cfg_t                   cfg
);
    import frmc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_TOO_FAR:      cfg_next.too_far      = cfg_data[SAMPLE_BITS-1:0];
                REG_FOLLOW_FAR:   cfg_next.fwd_edge     = cfg_data[SAMPLE_BITS-1:0];
                REG_FOLLOW_CLOSE: cfg_next.back_edge    = cfg_data[SAMPLE_BITS-1:0];
                REG_TOO_CLOSE:    cfg_next.close_limit  = cfg_data[SAMPLE_BITS-1:0];
                REG_PIVOT_DWELL:  cfg_next.pivot_dwell  = cfg_data[DWELL_BITS-1:0];
                REG_WALL_DWELL:   cfg_next.wall_dwell   = cfg_data[DWELL_BITS-1:0];
                REG_OBJECT_DWELL: cfg_next.object_dwell = cfg_data[DWELL_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.too_far      <= RST_TOO_FAR;
            cfg_reg.fwd_edge     <= RST_FOLLOW_FAR;
            cfg_reg.back_edge    <= RST_FOLLOW_CLOSE;
            cfg_reg.close_limit  <= RST_TOO_CLOSE;
            cfg_reg.pivot_dwell  <= RST_PIVOT_DWELL;
            cfg_reg.wall_dwell   <= RST_WALL_DWELL;
            cfg_reg.object_dwell <= RST_OBJECT_DWELL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/frmc_step.sv
// Decision logic of the follow robot mode controller: next state and result for one word.
// Purely combinational; depends on frmc_pkg for types and codes.
module frmc_step (
    input  frmc_pkg::cfg_t    cfg,
    input  frmc_pkg::state_t  state,
    input  frmc_pkg::item_t   item,
    output frmc_pkg::state_t  state_next,
    output frmc_pkg::result_t result
);
    import frmc_pkg::*;

    logic [DWELL_OUT_BITS-1:0] pivot_ext;
    logic [DWELL_OUT_BITS-1:0] wall_ext;
    logic [DWELL_OUT_BITS-1:0] object_ext;
    logic [DWELL_OUT_BITS-1:0] pivot_wall_sum;
    logic [DWELL_OUT_BITS-1:0] wall_twice;
    logic                      any_in_band;
    logic                      all_far;
    logic                      pick_left;
    logic                      pick_right;
    logic [SAMPLE_BITS-1:0]    lead;
    logic                      fwd_hit;
    logic                      back_hit;
    logic [CMD_BITS-1:0]       cmd_fwd;
    logic [CMD_BITS-1:0]       cmd_back;
    logic [SIDE_BITS-1:0]      side_now;
    logic [SAMPLE_BITS-1:0]    wall_lvl;

    function automatic logic in_band(input logic [SAMPLE_BITS-1:0] x,
                                     input cfg_t c);
        in_band = (x >= c.too_far) && (x <= c.close_limit);
    endfunction

    assign pivot_ext      = {1'b0, cfg.pivot_dwell};
    assign wall_ext       = {1'b0, cfg.wall_dwell};
    assign object_ext     = {1'b0, cfg.object_dwell};
    assign pivot_wall_sum = pivot_ext + wall_ext;
    assign wall_twice     = wall_ext + wall_ext;

    assign any_in_band = in_band(item.ahead, cfg) || in_band(item.left, cfg)
                         || in_band(item.right, cfg);
    assign all_far = (item.left < cfg.too_far) && (item.ahead < cfg.too_far)
                     && (item.right < cfg.too_far);

    // The ahead sensor wins every tie; left and right only win when strictly strongest.
    assign pick_left  = (item.left > item.ahead) && (item.left > item.right);
    assign pick_right = (item.right > item.ahead) && (item.right > item.left);

    always_comb
    begin
        lead     = item.ahead;
        cmd_fwd  = CMD_FWD;
        cmd_back = CMD_BACK;
        fwd_hit  = (item.ahead >= cfg.too_far) && (item.ahead <= cfg.fwd_edge);
        if (pick_left)
        begin
            lead     = item.left;
            cmd_fwd  = CMD_LFWD;
            cmd_back = CMD_LBACK;
            fwd_hit  = (item.left > cfg.too_far) && (item.left < cfg.fwd_edge);
        end
        else if (pick_right)
        begin
            lead     = item.right;
            cmd_fwd  = CMD_RFWD;
            cmd_back = CMD_RBACK;
            fwd_hit  = (item.right > cfg.too_far) && (item.right < cfg.fwd_edge);
        end
        back_hit = (lead < cfg.close_limit) && (lead > cfg.back_edge);
    end

    // A fresh wall run latches the nearer side on its first sample.
    assign side_now = (state.side != SIDE_NONE) ? state.side
                    : ((item.left < item.right) ? SIDE_RIGHT : SIDE_LEFT);
    assign wall_lvl = (side_now == SIDE_LEFT) ? item.left : item.right;

    always_comb
    begin
        state_next   = state;
        result.cmd   = CMD_HOLD;
        result.dwell = '0;
        if (item.req_type)
        begin
            if (item.sw1)
            begin
                state_next.armed = 1'b1;
                if (state_next.mode == MODE_INACTIVE)
                begin
                    state_next.mode     = MODE_OBJECT;
                    state_next.acquired = 1'b0;
                end
            end
            if (item.sw2 && state_next.armed)
            begin
                if (state_next.mode == MODE_WALL)
                begin
                    state_next.mode     = MODE_OBJECT;
                    state_next.side     = SIDE_NONE;
                    state_next.acquired = 1'b0;
                end
                else if (state_next.mode == MODE_OBJECT)
                begin
                    state_next.mode = MODE_WALL;
                end
            end
        end
        else if (state.mode == MODE_OBJECT)
        begin
            if (!state.acquired)
            begin
                state_next.acquired = any_in_band;
            end
            else
            begin
                result.dwell = object_ext;
                priority if (fwd_hit)
                begin
                    result.cmd = cmd_fwd;
                end
                else if (back_hit)
                begin
                    result.cmd = cmd_back;
                end
                else
                begin
                    result.cmd       = CMD_STOP;
                    state_next.mode  = MODE_INACTIVE;
                    state_next.armed = 1'b0;
                end
            end
        end
        else if (state.mode == MODE_WALL)
        begin
            state_next.side = side_now;
            priority if ((item.ahead > cfg.close_limit) && (wall_lvl > cfg.close_limit))
            begin
                result.cmd   = (side_now == SIDE_LEFT) ? CMD_RPIVOT : CMD_LPIVOT;
                result.dwell = pivot_wall_sum;
            end
            else if (wall_lvl > cfg.back_edge)
            begin
                result.cmd   = (side_now == SIDE_LEFT) ? CMD_FASTL : CMD_FASTR;
                result.dwell = pivot_ext;
            end
            else if ((wall_lvl < cfg.back_edge) && (wall_lvl > cfg.too_far))
            begin
                result.cmd   = (side_now == SIDE_LEFT) ? CMD_FASTR : CMD_FASTL;
                result.dwell = pivot_wall_sum;
            end
            else if (all_far)
            begin
                result.cmd   = (side_now == SIDE_LEFT) ? CMD_SHARPL : CMD_SHARPR;
                result.dwell = wall_twice;
            end
            else
            begin
                result.cmd   = CMD_STOP;
                result.dwell = '0;
            end
        end
        result.mode = state_next.mode;
    end

endmodule

FILE: rtl/follow_robot_mode_controller_top.sv
// An accepted word is held in the input register; its result is then loaded into the result register.
// Throughput: one word per cycle while out_ready holds; the input register feeds one pass of compare logic
// that updates the mode state and loads the result register in the same cycle.
// Reset clears the mode to inactive, the armed, acquired and wall side state, both
// pipeline valid flags, and loads the default thresholds and dwell times.
module follow_robot_mode_controller_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 req_type,
    input  logic [frmc_pkg::SAMPLE_BITS-1:0]     ahead_level,
    input  logic [frmc_pkg::SAMPLE_BITS-1:0]     left_level,
    input  logic [frmc_pkg::SAMPLE_BITS-1:0]     right_level,
    input  logic                                 sw1_pressed,
    input  logic                                 sw2_pressed,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [frmc_pkg::CMD_BITS-1:0]        motor_cmd,
    output logic [frmc_pkg::DWELL_OUT_BITS-1:0]  dwell_ticks,
    output logic [frmc_pkg::MODE_BITS-1:0]       led_color,
    output logic [frmc_pkg::MODE_BITS-1:0]       mode_now,
    input  logic                                 cfg_wen,
    input  logic [frmc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [frmc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import frmc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;
    logic    advance;
    logic    in_fire;

    frmc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    frmc_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // The held word moves into the result register whenever that register is free or drains.
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '{mode: MODE_INACTIVE, armed: 1'b0, acquired: 1'b0,
                                side: SIDE_NONE};
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= '{req_type: req_type, ahead: ahead_level, left: left_level,
                          right: right_level, sw1: sw1_pressed, sw2: sw2_pressed};
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign motor_cmd   = result_reg.cmd;
    assign dwell_ticks = result_reg.dwell;
    assign led_color   = result_reg.mode;
    assign mode_now    = result_reg.mode;

`include "follow_robot_mode_controller_top_macros.svh"

    `FRMC_ASSERT_IMPL(a_side_only_in_wall, state_reg.side != SIDE_NONE, state_reg.mode == MODE_WALL)
    `FRMC_ASSERT_IMPL(a_active_means_armed, state_reg.mode != MODE_INACTIVE, state_reg.armed)
    `FRMC_ASSERT_IMPL(a_hold_has_no_dwell, out_valid_reg && (result_reg.cmd == CMD_HOLD), result_reg.dwell == '0)
    `FRMC_ASSERT_NEXT(a_accept_fills_stage, in_fire, item_valid_reg)

endmodule

FILE: bench/frmc_motion_checker.sv
// Checker for the follow robot mode controller: watches both channels and the register port.
// It predicts each result word from its own copy of the mode state and compares in order.
// Depends on frmc_pkg for widths, command and mode codes, and register indexes.
module frmc_motion_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic                                 req_type,
    input  logic [frmc_pkg::SAMPLE_BITS-1:0]     ahead_level,
    input  logic [frmc_pkg::SAMPLE_BITS-1:0]     left_level,
    input  logic [frmc_pkg::SAMPLE_BITS-1:0]     right_level,
    input  logic                                 sw1_pressed,
    input  logic                                 sw2_pressed,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [frmc_pkg::CMD_BITS-1:0]        motor_cmd,
    input  logic [frmc_pkg::DWELL_OUT_BITS-1:0]  dwell_ticks,
    input  logic [frmc_pkg::MODE_BITS-1:0]       led_color,
    input  logic [frmc_pkg::MODE_BITS-1:0]       mode_now,
    input  logic                                 cfg_wen,
    input  logic [frmc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [frmc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output int                                   failures,
    output int                                   pending
);
    import frmc_pkg::*;

    cfg_t                 cfg;
    logic [MODE_BITS-1:0] mode_q;
    logic                 armed_q;
    logic                 acquired_q;
    logic [SIDE_BITS-1:0] side_q;
    result_t              expected_moves[$];

    function automatic logic in_band(logic [SAMPLE_BITS-1:0] x);
        return !(x < cfg.too_far || x > cfg.close_limit);
    endfunction

    function automatic void change_mode(logic [MODE_BITS-1:0] m);
        if (mode_q == MODE_WALL && m != MODE_WALL)
            side_q = SIDE_NONE;
        if (m == MODE_OBJECT && mode_q != MODE_OBJECT)
            acquired_q = 1'b0;
        mode_q = m;
    endfunction

    function automatic result_t next_motion(item_t it);
        result_t                   res;
        logic [SAMPLE_BITS-1:0]    lead;
        logic                      closed_band;
        logic                      fwd;
        logic                      back;
        logic                      all_far;
        logic [CMD_BITS-1:0]       cmd_fwd;
        logic [CMD_BITS-1:0]       cmd_back;
        logic [DWELL_OUT_BITS-1:0] pivot_only;
        logic [DWELL_OUT_BITS-1:0] mixed;
        logic [DWELL_OUT_BITS-1:0] wall_pair;
        res.cmd = CMD_HOLD;
        res.dwell = '0;
        pivot_only = DWELL_OUT_BITS'(cfg.pivot_dwell);
        mixed = DWELL_OUT_BITS'(cfg.pivot_dwell) + DWELL_OUT_BITS'(cfg.wall_dwell);
        wall_pair = DWELL_OUT_BITS'(cfg.wall_dwell) + DWELL_OUT_BITS'(cfg.wall_dwell);
        if (it.req_type)
        begin
            if (it.sw1)
            begin
                armed_q = 1'b1;
                if (mode_q == MODE_INACTIVE)
                    change_mode(MODE_OBJECT);
            end
            if (it.sw2 && armed_q)
            begin
                if (mode_q == MODE_WALL)
                    change_mode(MODE_OBJECT);
                else if (mode_q == MODE_OBJECT)
                    change_mode(MODE_WALL);
            end
        end
        else if (mode_q == MODE_OBJECT && !acquired_q)
        begin
            if (in_band(it.ahead) || in_band(it.left) || in_band(it.right))
                acquired_q = 1'b1;
        end
        else if (mode_q == MODE_OBJECT)
        begin
            lead = it.ahead;
            closed_band = 1'b1;
            cmd_fwd = CMD_FWD;
            cmd_back = CMD_BACK;
            if (!(it.ahead >= it.left && it.ahead >= it.right))
            begin
                if (it.left > it.ahead && it.left > it.right)
                begin
                    lead = it.left;
                    closed_band = 1'b0;
                    cmd_fwd = CMD_LFWD;
                    cmd_back = CMD_LBACK;
                end
                else if (it.right > it.ahead && it.right > it.left)
                begin
                    lead = it.right;
                    closed_band = 1'b0;
                    cmd_fwd = CMD_RFWD;
                    cmd_back = CMD_RBACK;
                end
            end
            if (closed_band)
                fwd = (cfg.too_far <= lead) && (lead <= cfg.fwd_edge);
            else
                fwd = (cfg.too_far < lead) && (lead < cfg.fwd_edge);
            back = (lead < cfg.close_limit) && (lead > cfg.back_edge);
            if (fwd)
            begin
                res.cmd = cmd_fwd;
            end
            else if (back)
            begin
                res.cmd = cmd_back;
            end
            else
            begin
                res.cmd = CMD_STOP;
                change_mode(MODE_INACTIVE);
                armed_q = 1'b0;
            end
            res.dwell = DWELL_OUT_BITS'(cfg.object_dwell);
        end
        else if (mode_q == MODE_WALL)
        begin
            all_far = (it.left < cfg.too_far) && (it.ahead < cfg.too_far)
                      && (it.right < cfg.too_far);
            if (side_q == SIDE_NONE)
                side_q = (it.left < it.right) ? SIDE_RIGHT : SIDE_LEFT;
            if (side_q == SIDE_LEFT)
            begin
                if (it.ahead > cfg.close_limit && it.left > cfg.close_limit)
                begin
                    res.cmd = CMD_RPIVOT;
                    res.dwell = mixed;
                end
                else if (it.left > cfg.back_edge)
                begin
                    res.cmd = CMD_FASTL;
                    res.dwell = pivot_only;
                end
                else if (it.left < cfg.back_edge && it.left > cfg.too_far)
                begin
                    res.cmd = CMD_FASTR;
                    res.dwell = mixed;
                end
                else if (all_far)
                begin
                    res.cmd = CMD_SHARPL;
                    res.dwell = wall_pair;
                end
                else
                begin
                    res.cmd = CMD_STOP;
                end
            end
            else
            begin
                if (it.ahead > cfg.close_limit && it.right > cfg.close_limit)
                begin
                    res.cmd = CMD_LPIVOT;
                    res.dwell = mixed;
                end
                else if (it.right < cfg.back_edge && it.right > cfg.too_far)
                begin
                    res.cmd = CMD_FASTL;
                    res.dwell = mixed;
                end
                else if (it.right > cfg.back_edge)
                begin
                    res.cmd = CMD_FASTR;
                    res.dwell = pivot_only;
                end
                else if (all_far)
                begin
                    res.cmd = CMD_SHARPR;
                    res.dwell = wall_pair;
                end
                else
                begin
                    res.cmd = CMD_STOP;
                end
            end
        end
        res.mode = mode_q;
        return res;
    endfunction

    task automatic report_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t oldest;
        item_t   word;
        if (!rst_n)
        begin
            cfg.too_far = RST_TOO_FAR;
            cfg.fwd_edge = RST_FOLLOW_FAR;
            cfg.back_edge = RST_FOLLOW_CLOSE;
            cfg.close_limit = RST_TOO_CLOSE;
            cfg.pivot_dwell = RST_PIVOT_DWELL;
            cfg.wall_dwell = RST_WALL_DWELL;
            cfg.object_dwell = RST_OBJECT_DWELL;
            mode_q = MODE_INACTIVE;
            armed_q = 1'b0;
            acquired_q = 1'b0;
            side_q = SIDE_NONE;
            expected_moves.delete();
            failures = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_moves.size() == 0)
                begin
                    failures++;
                    $display("%0t: result word with nothing expected, actual cmd %0d dwell %0d",
                             $time, motor_cmd, dwell_ticks);
                end
                else
                begin
                    oldest = expected_moves.pop_front();
                    report_field("motor_cmd", oldest.cmd, motor_cmd);
                    report_field("dwell_ticks", oldest.dwell, dwell_ticks);
                    report_field("led_color", oldest.mode, led_color);
                    report_field("mode_now", oldest.mode, mode_now);
                end
            end
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_TOO_FAR:      cfg.too_far = cfg_data[SAMPLE_BITS-1:0];
                    REG_FOLLOW_FAR:   cfg.fwd_edge = cfg_data[SAMPLE_BITS-1:0];
                    REG_FOLLOW_CLOSE: cfg.back_edge = cfg_data[SAMPLE_BITS-1:0];
                    REG_TOO_CLOSE:    cfg.close_limit = cfg_data[SAMPLE_BITS-1:0];
                    REG_PIVOT_DWELL:  cfg.pivot_dwell = cfg_data[DWELL_BITS-1:0];
                    REG_WALL_DWELL:   cfg.wall_dwell = cfg_data[DWELL_BITS-1:0];
                    REG_OBJECT_DWELL: cfg.object_dwell = cfg_data[DWELL_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                word.req_type = req_type;
                word.ahead = ahead_level;
                word.left = left_level;
                word.right = right_level;
                word.sw1 = sw1_pressed;
                word.sw2 = sw2_pressed;
                expected_moves.push_back(next_motion(word));
            end
        end
        pending = expected_moves.size();
    end

endmodule

FILE: bench/follow_robot_mode_controller_top_tb.sv
// Top of the follow robot mode controller bench: clock, reset, register setup and stimulus.
// Depends on frmc_pkg, the controller RTL and frmc_motion_checker, which does all checking.
module follow_robot_mode_controller_top_tb;
    import frmc_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int PHASE_WORDS = 290;
    localparam int PHASE_COUNT = 6;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      req_type = 1'b0;
    logic [SAMPLE_BITS-1:0]    ahead_level = '0;
    logic [SAMPLE_BITS-1:0]    left_level = '0;
    logic [SAMPLE_BITS-1:0]    right_level = '0;
    logic                      sw1_pressed = 1'b0;
    logic                      sw2_pressed = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [CMD_BITS-1:0]       motor_cmd;
    logic [DWELL_OUT_BITS-1:0] dwell_ticks;
    logic [MODE_BITS-1:0]      led_color;
    logic [MODE_BITS-1:0]      mode_now;
    logic                      cfg_wen = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    int                        failures;
    int                        pending;
    int                        level_marks[4];
    logic                      hold_request = 1'b0;
    logic                      hold_active = 1'b0;
    logic                      steady = 1'b0;

    follow_robot_mode_controller_top DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .ahead_level(ahead_level), .left_level(left_level),
        .right_level(right_level), .sw1_pressed(sw1_pressed), .sw2_pressed(sw2_pressed),
        .out_valid(out_valid), .out_ready(out_ready), .motor_cmd(motor_cmd),
        .dwell_ticks(dwell_ticks), .led_color(led_color), .mode_now(mode_now),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    frmc_motion_checker motion_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .ahead_level(ahead_level), .left_level(left_level),
        .right_level(right_level), .sw1_pressed(sw1_pressed), .sw2_pressed(sw2_pressed),
        .out_valid(out_valid), .out_ready(out_ready), .motor_cmd(motor_cmd),
        .dwell_ticks(dwell_ticks), .led_color(led_color), .mode_now(mode_now),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .pending(pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic item_t compose(logic rt, int a, int l, int r, logic s1, logic s2);
        item_t it;
        it.req_type = rt;
        it.ahead = SAMPLE_BITS'(a);
        it.left = SAMPLE_BITS'(l);
        it.right = SAMPLE_BITS'(r);
        it.sw1 = s1;
        it.sw2 = s2;
        return it;
    endfunction

    // Levels cluster on the current thresholds so that every band edge is hit often.
    function automatic int pick_level();
        int r;
        int mark;
        r = $urandom_range(0, 99);
        mark = level_marks[$urandom_range(0, 3)];
        if (r < 25)
            return $urandom_range(0, 4095);
        else if (r < 30)
            return 0;
        else if (r < 35)
            return 4095;
        else if (r < 60)
            return mark + int'($urandom_range(0, 2)) - 1;
        else if (r < 85)
            return mark + int'($urandom_range(0, 60)) - 30;
        return mark;
    endfunction

    function automatic item_t make_sample();
        return compose(1'b0, pick_level(), pick_level(), pick_level(),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic item_t make_button(logic s1, logic s2);
        return compose(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), s1, s2);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // The idle gap comes before the word, so valid drops at most once per word.
    task automatic send_word(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= it.req_type;
        ahead_level <= it.ahead;
        left_level <= it.left;
        right_level <= it.right;
        sw1_pressed <= it.sw1;
        sw2_pressed <= it.sw2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int data);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_BITS'(data);
        @(posedge clk);
    endtask

    task automatic program_all(input int too_far, input int fwd_edge, input int back_edge,
                               input int close_limit, input int pivot, input int wall,
                               input int object);
        level_marks[0] = too_far % 4096;
        level_marks[1] = fwd_edge % 4096;
        level_marks[2] = back_edge % 4096;
        level_marks[3] = close_limit % 4096;
        write_reg(REG_TOO_FAR, too_far);
        write_reg(REG_FOLLOW_FAR, fwd_edge);
        write_reg(REG_FOLLOW_CLOSE, back_edge);
        write_reg(REG_TOO_CLOSE, close_limit);
        write_reg(REG_PIVOT_DWELL, pivot);
        write_reg(REG_WALL_DWELL, wall);
        write_reg(REG_OBJECT_DWELL, object);
        cfg_wen <= 1'b0;
    endtask

    task automatic program_ordered();
        int t0;
        int t1;
        int t2;
        t0 = $urandom_range(0, 1000);
        t1 = t0 + $urandom_range(0, 1000);
        t2 = t1 + $urandom_range(0, 1000);
        program_all(t0, t1, t2, t2 + $urandom_range(0, 1000), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // A session arms the block, tracks in object mode and often toggles into wall mode.
    task automatic run_sessions(input int target);
        int sent;
        sent = 0;
        while (sent < target)
        begin
            steady = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(0, 2))
                send_word(compose(1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                                  $urandom_range(0, 4095), $urandom_range(0, 4095),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            send_word(make_button(1'b1, $urandom_range(0, 4) == 0));
            sent++;
            repeat ($urandom_range(2, 16))
            begin
                send_word(make_sample());
                sent++;
            end
            if ($urandom_range(0, 9) < 6)
            begin
                send_word(make_button(1'($urandom_range(0, 1)), 1'b1));
                sent++;
                repeat ($urandom_range(2, 16))
                begin
                    send_word(make_sample());
                    sent++;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    send_word(make_button(1'b0, 1'b1));
                    sent++;
                    repeat ($urandom_range(1, 8))
                    begin
                        send_word(make_sample());
                        sent++;
                    end
                end
            end
        end
        steady = 1'b0;
    endtask

    // The receiver holds off for a long stretch while words keep coming, so the block fills.
    task automatic fill_and_stall();
        in_valid <= 1'b0;
        hold_request = 1'b1;
        while (!hold_active)
            @(posedge clk);
        steady = 1'b1;
        send_word(make_button(1'b1, 1'b0));
        repeat (60) send_word(make_sample());
        steady = 1'b0;
    endtask

    initial
    begin : receiver
        int r;
        int len;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_active = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    out_ready <= 1'b1;
                    len = 1;
                end
                else if (r < 75)
                begin
                    out_ready <= 1'b1;
                    len = $urandom_range(5, 30);
                end
                else if (r < 95)
                begin
                    out_ready <= 1'b0;
                    len = $urandom_range(1, 3);
                end
                else
                begin
                    out_ready <= 1'b0;
                    len = $urandom_range(10, 40);
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(REG_UNUSED, 16'hFFFF);
        program_all(RST_TOO_FAR, RST_FOLLOW_FAR, RST_FOLLOW_CLOSE, RST_TOO_CLOSE,
                    RST_PIVOT_DWELL, RST_WALL_DWELL, RST_OBJECT_DWELL);
        @(posedge clk);

        send_word(compose(1'b0, 4095, 4095, 4095, 1'b1, 1'b1));
        send_word(compose(1'b1, 0, 0, 0, 1'b0, 1'b0));
        send_word(compose(1'b1, 4095, 4095, 4095, 1'b0, 1'b1));
        send_word(compose(1'b1, 0, 0, 0, 1'b1, 1'b0));
        send_word(compose(1'b0, 4095, 100, 3001, 1'b0, 1'b0));
        send_word(compose(1'b0, 1000, 0, 0, 1'b0, 1'b0));
        send_word(compose(1'b0, 1000, 1000, 0, 1'b0, 1'b0));
        send_word(compose(1'b0, 100, 1200, 100, 1'b0, 1'b0));
        send_word(compose(1'b0, 100, 100, 2500, 1'b0, 1'b0));
        send_word(compose(1'b0, 600, 0, 0, 1'b0, 1'b0));
        send_word(compose(1'b0, 1500, 0, 0, 1'b0, 1'b0));
        send_word(compose(1'b0, 0, 1000, 1000, 1'b0, 1'b0));
        send_word(compose(1'b1, 0, 0, 0, 1'b1, 1'b1));
        send_word(compose(1'b0, 700, 2500, 2500, 1'b0, 1'b0));
        send_word(compose(1'b0, 4095, 4095, 0, 1'b0, 1'b0));
        send_word(compose(1'b0, 700, 1000, 0, 1'b0, 1'b0));
        send_word(compose(1'b0, 0, 0, 0, 1'b0, 1'b0));
        send_word(compose(1'b0, 700, 2000, 0, 1'b0, 1'b0));
        send_word(compose(1'b1, 0, 0, 0, 1'b0, 1'b1));
        send_word(compose(1'b0, 2500, 0, 0, 1'b0, 1'b0));
        send_word(compose(1'b0, 2500, 0, 0, 1'b0, 1'b0));
        send_word(compose(1'b1, 0, 0, 0, 1'b0, 1'b1));
        send_word(compose(1'b0, 700, 100, 2500, 1'b0, 1'b0));
        send_word(compose(1'b0, 700, 0, 1000, 1'b0, 1'b0));
        send_word(compose(1'b0, 4095, 0, 4095, 1'b0, 1'b0));
        send_word(compose(1'b0, 0, 0, 0, 1'b0, 1'b0));
        send_word(compose(1'b1, 0, 0, 0, 1'b1, 1'b0));
        drain();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                1: program_all(0, 0, 0, 0, 0, 0, 0);
                2: program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: program_ordered();
                4: program_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535));
                5: program_ordered();
                default: ;
            endcase
            if (phase != 0)
                @(posedge clk);
            if (phase == 3)
                fill_and_stall();
            run_sessions(PHASE_WORDS);
            drain();
        end

        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
